@@ hw/rtl/cpt_pkg.sv @@
// cpt_pkg: widths, payload structs, region and weight-mode codes for the
// closest point on triangle block. No dependencies.
`default_nettype none
package cpt_pkg;

  localparam int CW     = 16;
  localparam int WFB    = 16;
  localparam int DW     = CW + 1;
  localparam int PW     = 2 * DW;
  localparam int QW     = PW + 2;
  localparam int PPW    = 2 * QW;
  localparam int NW     = PPW + 2;
  localparam int UW     = NW - 1;
  localparam int WW     = WFB + 1;
  localparam int PSW    = WW + 1 + DW;
  localparam int AW     = CW + WFB + 4;
  localparam int QDEPTH = 4;

  localparam logic [WW-1:0] W_ONE = {1'b1, {WFB{1'b0}}};

  localparam logic [2:0] RG_INTERIOR = 3'd0;
  localparam logic [2:0] RG_EDGE_ST1 = 3'd1;
  localparam logic [2:0] RG_EDGE_S0  = 3'd2;
  localparam logic [2:0] RG_EDGE_T0  = 3'd3;
  localparam logic [2:0] RG_V0       = 3'd4;
  localparam logic [2:0] RG_V2       = 3'd5;
  localparam logic [2:0] RG_V1       = 3'd6;

  typedef enum logic [1:0] {WM_ZERO, WM_ONE, WM_DIV} wmode_t;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [DW-1:0] dif_t;

  typedef struct packed {
    crd_t vertex0_x;
    crd_t vertex0_y;
    crd_t vertex0_z;
    crd_t vertex1_x;
    crd_t vertex1_y;
    crd_t vertex1_z;
    crd_t vertex2_x;
    crd_t vertex2_y;
    crd_t vertex2_z;
    crd_t query_x;
    crd_t query_y;
    crd_t query_z;
  } in_t;

  typedef struct packed {
    crd_t          nearest_x;
    crd_t          nearest_y;
    crd_t          nearest_z;
    logic [WW-1:0] weight_s;
    logic [WW-1:0] weight_t;
    logic [2:0]    region_code;
    logic          degenerate;
  } out_t;

  typedef struct packed {
    crd_t [2:0] p0;
    dif_t [2:0] e0;
    dif_t [2:0] e1;
  } geo_t;

  typedef struct packed {
    geo_t          geo;
    logic [2:0]    region;
    logic          degen;
    wmode_t        s_mode;
    wmode_t        t_mode;
    logic          t_from_s;
    logic [UW-1:0] s_num;
    logic [UW-1:0] s_den;
    logic [UW-1:0] t_num;
    logic [UW-1:0] t_den;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

@@ hw/rtl/cpt_front.sv @@
// cpt_front: five-stage front end, dot products, gram terms, region choice
// and weight quotient set-up. Depends on cpt_pkg.
`default_nettype none
module cpt_front import cpt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_data,
  input  qstat_t q_stat,
  output logic   q_push,
  output item_t  q_item
);

  function automatic logic signed [QW-1:0] dot3(input dif_t x0, input dif_t x1,
                                                input dif_t x2, input dif_t y0,
                                                input dif_t y1, input dif_t y2);
    logic signed [PW-1:0] m0, m1, m2;
    begin
      m0 = x0 * y0;
      m1 = x1 * y1;
      m2 = x2 * y2;
      return QW'(m0) + QW'(m1) + QW'(m2);
    end
  endfunction

  logic       adv;
  logic [4:0] v_r;

  assign adv      = ~(v_r[4] & q_stat.full);
  assign in_ready = adv;
  assign q_push   = v_r[4] & ~q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // stage 1: edges and dot products
  geo_t g0;
  dif_t w0, w1, w2;
  always_comb begin
    g0.p0[0] = in_data.vertex0_x;
    g0.p0[1] = in_data.vertex0_y;
    g0.p0[2] = in_data.vertex0_z;
    g0.e0[0] = DW'(in_data.vertex1_x) - DW'(in_data.vertex0_x);
    g0.e0[1] = DW'(in_data.vertex1_y) - DW'(in_data.vertex0_y);
    g0.e0[2] = DW'(in_data.vertex1_z) - DW'(in_data.vertex0_z);
    g0.e1[0] = DW'(in_data.vertex2_x) - DW'(in_data.vertex0_x);
    g0.e1[1] = DW'(in_data.vertex2_y) - DW'(in_data.vertex0_y);
    g0.e1[2] = DW'(in_data.vertex2_z) - DW'(in_data.vertex0_z);
    w0 = DW'(in_data.vertex0_x) - DW'(in_data.query_x);
    w1 = DW'(in_data.vertex0_y) - DW'(in_data.query_y);
    w2 = DW'(in_data.vertex0_z) - DW'(in_data.query_z);
  end

  geo_t                 g1_r;
  logic signed [QW-1:0] da1_r, db1_r, dc1_r, dd1_r, de1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r  <= g0;
      da1_r <= dot3(g0.e0[0], g0.e0[1], g0.e0[2], g0.e0[0], g0.e0[1], g0.e0[2]);
      db1_r <= dot3(g0.e0[0], g0.e0[1], g0.e0[2], g0.e1[0], g0.e1[1], g0.e1[2]);
      dc1_r <= dot3(g0.e1[0], g0.e1[1], g0.e1[2], g0.e1[0], g0.e1[1], g0.e1[2]);
      dd1_r <= dot3(g0.e0[0], g0.e0[1], g0.e0[2], w0, w1, w2);
      de1_r <= dot3(g0.e1[0], g0.e1[1], g0.e1[2], w0, w1, w2);
    end
  end

  // stage 2: gram products
  geo_t                  g2_r;
  logic signed [QW-1:0]  da2_r, db2_r, dc2_r, dd2_r, de2_r;
  logic signed [PPW-1:0] ac2_r, bb2_r, be2_r, cd2_r, bd2_r, ae2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_r  <= g1_r;
      da2_r <= da1_r;
      db2_r <= db1_r;
      dc2_r <= dc1_r;
      dd2_r <= dd1_r;
      de2_r <= de1_r;
      ac2_r <= da1_r * dc1_r;
      bb2_r <= db1_r * db1_r;
      be2_r <= db1_r * de1_r;
      cd2_r <= dc1_r * dd1_r;
      bd2_r <= db1_r * dd1_r;
      ae2_r <= da1_r * de1_r;
    end
  end

  // stage 3: determinant, numerators, edge terms
  geo_t                 g3_r;
  logic signed [NW-1:0] det3_r, sn3_r, tn3_r, den3_r, edge3_r;
  logic signed [NW-1:0] a3_r, c3_r, d3_r, e3_r;
  logic                 lt5_3_r, lt6_3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g3_r    <= g2_r;
      det3_r  <= NW'(ac2_r) - NW'(bb2_r);
      sn3_r   <= NW'(be2_r) - NW'(cd2_r);
      tn3_r   <= NW'(bd2_r) - NW'(ae2_r);
      den3_r  <= NW'(da2_r) - NW'(db2_r) - NW'(db2_r) + NW'(dc2_r);
      edge3_r <= NW'(dc2_r) + NW'(de2_r) - NW'(db2_r) - NW'(dd2_r);
      lt5_3_r <= (NW'(db2_r) + NW'(dd2_r)) < (NW'(dc2_r) + NW'(de2_r));
      lt6_3_r <= (NW'(db2_r) + NW'(de2_r)) < (NW'(da2_r) + NW'(dd2_r));
      a3_r    <= NW'(da2_r);
      c3_r    <= NW'(dc2_r);
      d3_r    <= NW'(dd2_r);
      e3_r    <= NW'(de2_r);
    end
  end

  // stage 4: region choice
  logic signed [NW-1:0] sn_num, sn_den, tn_num, tn_den, sum34;
  logic [2:0]           rg4;
  logic                 tfs4;

  always_comb begin
    sum34  = sn3_r + tn3_r;
    sn_num = '0;
    sn_den = NW'(1);
    tn_num = '0;
    tn_den = NW'(1);
    tfs4   = 1'b0;
    priority if (sum34 < det3_r) begin
      if (sn3_r[NW-1]) begin
        if (tn3_r[NW-1]) begin
          rg4 = RG_V0;
          if (d3_r[NW-1]) begin
            sn_num = -d3_r;
            sn_den = a3_r;
          end else begin
            tn_num = -e3_r;
            tn_den = c3_r;
          end
        end else begin
          rg4    = RG_EDGE_S0;
          tn_num = -e3_r;
          tn_den = c3_r;
        end
      end else if (tn3_r[NW-1]) begin
        rg4    = RG_EDGE_T0;
        sn_num = -d3_r;
        sn_den = a3_r;
      end else begin
        rg4    = RG_INTERIOR;
        sn_num = sn3_r;
        sn_den = det3_r;
        tn_num = tn3_r;
        tn_den = det3_r;
      end
    end else begin
      if (sn3_r[NW-1]) begin
        rg4 = RG_V2;
        if (lt5_3_r) begin
          sn_num = edge3_r;
          sn_den = den3_r;
          tfs4   = 1'b1;
        end else begin
          tn_num = -e3_r;
          tn_den = c3_r;
        end
      end else if (tn3_r[NW-1]) begin
        rg4 = RG_V1;
        if (lt6_3_r) begin
          sn_num = edge3_r;
          sn_den = den3_r;
          tfs4   = 1'b1;
        end else begin
          sn_num = -d3_r;
          sn_den = a3_r;
        end
      end else begin
        rg4    = RG_EDGE_ST1;
        sn_num = edge3_r;
        sn_den = den3_r;
        tfs4   = 1'b1;
      end
    end
  end

  geo_t                 g4_r;
  logic signed [NW-1:0] sn4_r, sd4_r, tn4_r, td4_r;
  logic [2:0]           rg4_r;
  logic                 tfs4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g4_r   <= g3_r;
      sn4_r  <= sn_num;
      sd4_r  <= sn_den;
      tn4_r  <= tn_num;
      td4_r  <= tn_den;
      rg4_r  <= rg4;
      tfs4_r <= tfs4;
    end
  end

  // stage 5: quotient clamping and zero or negative divisor detection
  logic   s_dg, t_dg;
  wmode_t s_md, t_md;

  always_comb begin
    s_dg = sd4_r[NW-1] | (sd4_r == '0);
    t_dg = td4_r[NW-1] | (td4_r == '0);
    priority if (s_dg || sn4_r[NW-1] || sn4_r == '0) s_md = WM_ZERO;
    else if (sn4_r >= sd4_r) s_md = WM_ONE;
    else s_md = WM_DIV;
    priority if (t_dg || tn4_r[NW-1] || tn4_r == '0) t_md = WM_ZERO;
    else if (tn4_r >= td4_r) t_md = WM_ONE;
    else t_md = WM_DIV;
  end

  item_t it5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      it5_r.geo      <= g4_r;
      it5_r.region   <= rg4_r;
      it5_r.degen    <= s_dg | t_dg;
      it5_r.s_mode   <= s_md;
      it5_r.t_mode   <= t_md;
      it5_r.t_from_s <= tfs4_r;
      it5_r.s_num    <= sn4_r[UW-1:0];
      it5_r.s_den    <= sd4_r[UW-1:0];
      it5_r.t_num    <= tn4_r[UW-1:0];
      it5_r.t_den    <= td4_r[UW-1:0];
    end
  end

  assign q_item = it5_r;

endmodule
`default_nettype wire

@@ hw/rtl/cpt_fifo.sv @@
// cpt_fifo: short request queue between front and back end.
// Depends on cpt_pkg.
`default_nettype none
module cpt_fifo import cpt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  pop_item,
  output qstat_t stat
);

  localparam int PTRW = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  item_t           mem [QDEPTH];
  logic [PTRW-1:0] wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;

  assign stat.full  = (cnt_r == CNTW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_item   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PTRW'(1);
      if (pop) rp_r <= rp_r + PTRW'(1);
      cnt_r <= cnt_r + CNTW'(push) - CNTW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("push into full queue");

endmodule
`default_nettype wire

@@ hw/rtl/cpt_back.sv @@
// cpt_back: pipelined restoring dividers for the weights, weight resolve and
// nearest point reconstruction with output register. Depends on cpt_pkg.
`default_nettype none
module cpt_back import cpt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  qstat_t q_stat,
  input  item_t  q_item,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  typedef struct packed {
    item_t          it;
    logic [WFB-1:0] qs;
    logic [WFB-1:0] qt;
  } dst_t;

  localparam logic signed [AW-1:0] HALF = AW'(1) << (WFB - 1);

  function automatic logic [UW:0] div_step(input logic [UW-1:0] r,
                                           input logic [UW-1:0] d);
    logic [UW:0] r2, df;
    begin
      r2 = {r, 1'b0};
      df = r2 - {1'b0, d};
      if (r2 >= {1'b0, d}) return {1'b1, df[UW-1:0]};
      else return {1'b0, r2[UW-1:0]};
    end
  endfunction

  function automatic logic [WW-1:0] wsel(input wmode_t m, input logic [WFB-1:0] q);
    begin
      unique case (m)
        WM_ONE:  return W_ONE;
        WM_DIV:  return {1'b0, q};
        default: return '0;
      endcase
    end
  endfunction

  logic adv, out_valid_r;
  out_t out_data_r;

  assign adv       = ~out_valid_r | out_ready;
  assign q_pop     = adv & ~q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dst_t           ds_r [WFB];
  logic [WFB-1:0] dv_r;

  for (genvar k = 0; k < WFB; k++) begin : g_div
    dst_t        src, d_nxt;
    logic [UW:0] ss, st;
    if (k == 0) begin : g_first
      assign src = '{it: q_item, qs: '0, qt: '0};
    end else begin : g_next
      assign src = ds_r[k-1];
    end
    always_comb begin
      d_nxt          = src;
      ss             = div_step(src.it.s_num, src.it.s_den);
      st             = div_step(src.it.t_num, src.it.t_den);
      d_nxt.it.s_num = ss[UW-1:0];
      d_nxt.it.t_num = st[UW-1:0];
      d_nxt.qs       = {src.qs[WFB-2:0], ss[UW]};
      d_nxt.qt       = {src.qt[WFB-2:0], st[UW]};
    end
    always_ff @(posedge clk) begin
      if (adv) ds_r[k] <= d_nxt;
    end
  end

  // weight resolve
  dst_t          last;
  logic [WW-1:0] s_w, t_w;
  assign last = ds_r[WFB-1];

  always_comb begin
    s_w = wsel(last.it.s_mode, last.qs);
    if (last.it.t_from_s) t_w = W_ONE - s_w;
    else t_w = wsel(last.it.t_mode, last.qt);
  end

  logic          v1_r, v2_r;
  geo_t          g1_r;
  logic [WW-1:0] s1_r, t1_r, s2_r, t2_r;
  logic [2:0]    rg1_r, rg2_r;
  logic          dg1_r, dg2_r;

  logic signed [PSW-1:0] ps2_r [3];
  logic signed [PSW-1:0] pt2_r [3];
  crd_t                  p02_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      dv_r        <= {dv_r[WFB-2:0], ~q_stat.empty};
      v1_r        <= dv_r[WFB-1];
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r  <= last.it.geo;
      s1_r  <= s_w;
      t1_r  <= t_w;
      rg1_r <= last.it.region;
      dg1_r <= last.it.degen;
      for (int i = 0; i < 3; i++) begin
        ps2_r[i] <= $signed({1'b0, s1_r}) * $signed(g1_r.e0[i]);
        pt2_r[i] <= $signed({1'b0, t1_r}) * $signed(g1_r.e1[i]);
        p02_r[i] <= g1_r.p0[i];
      end
      s2_r  <= s1_r;
      t2_r  <= t1_r;
      rg2_r <= rg1_r;
      dg2_r <= dg1_r;
    end
  end

  // point reconstruction, floor after half-unit bias
  logic signed [AW-1:0] acc [3];
  logic signed [AW-1:0] shr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (AW'(p02_r[i]) <<< WFB) + AW'(ps2_r[i]) + AW'(pt2_r[i]) + HALF;
      shr[i] = acc[i] >>> WFB;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.nearest_x   <= shr[0][CW-1:0];
      out_data_r.nearest_y   <= shr[1][CW-1:0];
      out_data_r.nearest_z   <= shr[2][CW-1:0];
      out_data_r.weight_s    <= s2_r;
      out_data_r.weight_t    <= t2_r;
      out_data_r.region_code <= rg2_r;
      out_data_r.degenerate  <= dg2_r;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/closest_point_on_triangle_top.sv @@
// closest_point_on_triangle_top: front end, request queue and back end.
// Depends on cpt_pkg, cpt_front, cpt_fifo, cpt_back.
// Throughput: one request per cycle while out_ready is high and the queue
// is not full, set by the fully pipelined products and the sixteen-stage
// weight dividers.
// Reset: synchronous active-low, clears stage valid bits and queue pointers.
`default_nettype none
module closest_point_on_triangle_top import cpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  qstat_t q_stat;
  logic   q_push, q_pop;
  item_t  q_in, q_out;

  cpt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  cpt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .stat      (q_stat)
  );

  cpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
